FILE: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types for the positional list core: operation and status codes,
// controller states and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    ins;
        logic    del;
        logic    res_load;
        status_t res_status;
        logic    dump_start;
        logic    dump_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic out_free;
        logic dump_emit;
        logic dump_done;
    } stat_t;

endpackage

FILE: rtl/core/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Controller: decodes each accepted operation, checks it against the list
// flags and sequences the dump walk over the entry array.
// ----------------------------------------------------------------------------
module pli_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      mode,
    input  pli_pkg::stat_t  stat,
    output pli_pkg::cmd_t   cmd
);

    pli_pkg::state_t state_reg;
    pli_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pli_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic accept;
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = pli_pkg::STAT_OK;
        s_tready       = 1'b0;
        accept         = 1'b0;
        unique case (state_reg)
            pli_pkg::S_IDLE: begin
                s_tready = stat.out_free;
                accept   = s_tvalid && stat.out_free;
                if (accept) begin
                    unique case (mode)
                        pli_pkg::MODE_INSERT: begin
                            cmd.res_load = 1'b1;
                            if (stat.pos_gt_cnt) begin
                                cmd.res_status = pli_pkg::STAT_BADPOS;
                            end else if (stat.full) begin
                                cmd.res_status = pli_pkg::STAT_FULL;
                            end else begin
                                cmd.ins = 1'b1;
                            end
                        end
                        pli_pkg::MODE_DELETE: begin
                            cmd.res_load = 1'b1;
                            if (stat.empty) begin
                                cmd.res_status = pli_pkg::STAT_EMPTY;
                            end else if (stat.pos_ge_cnt) begin
                                cmd.res_status = pli_pkg::STAT_BADPOS;
                            end else begin
                                cmd.del = 1'b1;
                            end
                        end
                        pli_pkg::MODE_DUMP: begin
                            if (stat.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = pli_pkg::STAT_EMPTY;
                            end else begin
                                cmd.dump_start = 1'b1;
                                state_next     = pli_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = pli_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end
            pli_pkg::S_DUMP: begin
                // rotation steps past the live entries need no output slot
                cmd.dump_step = stat.dump_emit ? stat.out_free : 1'b1;
                if (cmd.dump_step && stat.dump_done) begin
                    state_next = pli_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pli_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Entry array with one-step shift for insert and delete, a rotating walk for
// dump, the entry count and the result register.
// ----------------------------------------------------------------------------
module pli_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [4:0]          position,
    input  logic signed [31:0]  value,
    input  pli_pkg::cmd_t       cmd,
    output pli_pkg::stat_t      stat,
    input  logic                m_tready,
    output logic                m_valid,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_entry_value,
    output logic [3:0]          m_entry_index,
    output logic [4:0]          m_count,
    output logic                m_last
);

    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int RotW = $clog2(CAPACITY);
    localparam int CmpW = (CntW > 5) ? CntW : 5;

    logic [31:0]     entries_reg [CAPACITY];
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic [RotW-1:0] rot_reg;
    logic [CmpW-1:0] pos_w;
    logic [CmpW-1:0] cnt_w;
    logic            emit_last_w;

    logic               valid_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] value_reg;
    logic [3:0]         index_reg;
    logic [4:0]         count_reg;
    logic               last_reg;

    assign pos_w = CmpW'(position);
    assign cnt_w = CmpW'(cnt_reg);

    assign stat.empty      = (cnt_reg == '0);
    assign stat.full       = (cnt_reg == CntW'(CAPACITY));
    assign stat.pos_gt_cnt = (pos_w > cnt_w);
    assign stat.pos_ge_cnt = (pos_w >= cnt_w);
    assign stat.out_free   = !valid_reg || m_tready;
    assign stat.dump_emit  = (CntW'(rot_reg) < cnt_reg);
    assign stat.dump_done  = (rot_reg == RotW'(CAPACITY - 1));

    assign emit_last_w = ((CntW'(rot_reg) + CntW'(1)) == cnt_reg);

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ins) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (cmd.del) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
        logic [31:0] below_w;
        logic [31:0] above_w;
        logic [31:0] rot_src_w;

        if (g == 0) begin : g_first
            assign below_w = value;
        end else begin : g_inner_lo
            assign below_w = entries_reg[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign above_w   = entries_reg[g];
            assign rot_src_w = entries_reg[0];
        end else begin : g_inner_hi
            assign above_w   = entries_reg[g+1];
            assign rot_src_w = entries_reg[g+1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.ins && (pos_w <= CmpW'(g))) begin
                entries_reg[g] <= (pos_w == CmpW'(g)) ? value : below_w;
            end else if (cmd.del && (pos_w <= CmpW'(g))) begin
                entries_reg[g] <= above_w;
            end else if (cmd.dump_step) begin
                entries_reg[g] <= rot_src_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rot_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.dump_start) begin
                rot_reg <= '0;
            end else if (cmd.dump_step) begin
                rot_reg <= rot_reg + RotW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.res_load || (cmd.dump_step && stat.dump_emit)) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            status_reg <= cmd.res_status;
            value_reg  <= '0;
            index_reg  <= '0;
            count_reg  <= 5'(cnt_next);
            last_reg   <= 1'b1;
        end else if (cmd.dump_step && stat.dump_emit) begin
            status_reg <= pli_pkg::STAT_OK;
            value_reg  <= entries_reg[0];
            index_reg  <= 4'(rot_reg);
            count_reg  <= 5'(cnt_reg);
            last_reg   <= emit_last_w;
        end
    end

    assign m_valid       = valid_reg;
    assign m_status      = status_reg;
    assign m_entry_value = value_reg;
    assign m_entry_index = index_reg;
    assign m_count       = count_reg;
    assign m_last        = last_reg;

endmodule

FILE: rtl/core/positional_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of signed 32-bit words with insert, delete and dump by position.
// ----------------------------------------------------------------------------
// Usage: each input beat on the s_ channel carries one operation. Insert and
// delete shift the entries from the given position on and return one result
// beat, with tlast high, in the cycle after acceptance; a new operation can be
// taken every cycle as long as the result register is free or being drained.
// Dump of a non-empty list walks the array by rotating it one place per cycle,
// save where an output stall holds it, until it is back in its original order,
// sending one result beat per live entry (tlast on the final one); no input is
// taken during the walk. A dump of an empty list returns one beat with status
// empty. Failing operations leave the list untouched and report full, bad
// position or empty in status.
// Reset clears the entry count and the result valid; entries need no clear.
// A stall on m_tready holds the result register; the block then stops taking
// input (or stops the walk while on live entries) until the pending beat is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], position[6:2], value[38:7], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], entry_value[33:2],
                                   // entry_index[37:34], count[42:38], zero pad
    output logic        m_tlast
);

    pli_pkg::cmd_t  cmd;
    pli_pkg::stat_t stat;

    logic [1:0]         in_mode;
    logic [4:0]         in_position;
    logic signed [31:0] in_value;

    logic [1:0]         out_status;
    logic signed [31:0] out_value;
    logic [3:0]         out_index;
    logic [4:0]         out_count;

    assign in_mode     = s_tdata[1:0];
    assign in_position = s_tdata[6:2];
    assign in_value    = s_tdata[38:7];

    pli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (in_mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    pli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .position      (in_position),
        .value         (in_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_valid       (m_tvalid),
        .m_status      (out_status),
        .m_entry_value (out_value),
        .m_entry_index (out_index),
        .m_count       (out_count),
        .m_last        (m_tlast)
    );

    assign m_tdata = {5'b0, out_count, out_index, out_value, out_status};

endmodule
